>>> hdl/grid_maze_router_defines.svh
// ---------------------------------------------------------------------------
// grid_maze_router_defines.svh
// Assertion macros used by the maze router datapath.
// ---------------------------------------------------------------------------
`ifndef GRID_MAZE_ROUTER_DEFINES_SVH
`define GRID_MAZE_ROUTER_DEFINES_SVH

// same-cycle implication, off during reset
`define GMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define GMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gmr_pkg.sv
// ---------------------------------------------------------------------------
// gmr_pkg
// Types, codes and control/status bundles of the maze router.
// ---------------------------------------------------------------------------
package gmr_pkg;

    localparam int COORD_W = 5;
    localparam int STEP_W  = 10;
    localparam int LEN_W   = 11;

    localparam logic [COORD_W-1:0] START_COL_RST = 5'd0;
    localparam logic [COORD_W-1:0] START_ROW_RST = 5'd0;
    localparam logic [COORD_W-1:0] GOAL_COL_RST  = 5'd31;
    localparam logic [COORD_W-1:0] GOAL_ROW_RST  = 5'd31;

    typedef enum logic [1:0] {
        CMD_MARK   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_STEP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_START_COL = 2'd0,
        REG_START_ROW = 2'd1,
        REG_GOAL_COL  = 2'd2,
        REG_GOAL_ROW  = 2'd3
    } cfg_reg_t;

    // neighbor visiting order
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_UP    = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef struct packed {
        logic load_item;
        logic clr_en;
        logic seed;
        logic trivial;
        logic q_read;
        logic cell_load;
        logic lab_load;
        logic dir_reset;
        logic dir_next;
        logic nb_commit;
        logic goal_hit;
        logic tr_move;
        logic tr_found;
        logic obst;
        logic step_read;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        cmd_t new_cmd;
        logic clr_last;
        logic ep_bad;
        logic ep_same;
        logic q_empty;
        logic nb_valid;
        logic nb_is_goal;
        logic nb_free;
        logic dir_last;
        logic pos_zero;
        logic tr_hit;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/gmr_in_if.sv
// ---------------------------------------------------------------------------
// gmr_in_if
// Request channel: command word with valid/ready.
// ---------------------------------------------------------------------------
interface gmr_in_if;
    import gmr_pkg::*;

    logic                valid;
    logic                ready;
    cmd_t                command;
    logic [COORD_W-1:0]  cell_col;
    logic [COORD_W-1:0]  cell_row;
    logic [STEP_W-1:0]   step_index;

    modport source (output valid, command, cell_col, cell_row, step_index, input ready);
    modport sink   (input valid, command, cell_col, cell_row, step_index, output ready);
endinterface

>>> hdl/gmr_out_if.sv
// ---------------------------------------------------------------------------
// gmr_out_if
// Response channel: result word with valid/ready.
// ---------------------------------------------------------------------------
interface gmr_out_if;
    import gmr_pkg::*;

    logic                valid;
    logic                ready;
    logic                rejected;
    logic                found;
    logic [LEN_W-1:0]    path_length;
    logic [COORD_W-1:0]  step_col;
    logic [COORD_W-1:0]  step_row;

    modport source (output valid, rejected, found, path_length, step_col, step_row,
                    input ready);
    modport sink   (input valid, rejected, found, path_length, step_col, step_row,
                    output ready);
endinterface

>>> hdl/gmr_ctrl.sv
// ---------------------------------------------------------------------------
// gmr_ctrl
// Sequencer: command dispatch, map clears, wave expansion and trace-back.
// ---------------------------------------------------------------------------
module gmr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gmr_pkg::stat_t  st,
    output gmr_pkg::ctrl_t  ctl
);
    import gmr_pkg::*;

    typedef enum logic [13:0] {
        ST_BOOT  = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_MARK  = 14'b00000000000100,
        ST_STEP  = 14'b00000000001000,
        ST_CLR   = 14'b00000000010000,
        ST_SINIT = 14'b00000000100000,
        ST_QRD   = 14'b00000001000000,
        ST_CRD   = 14'b00000010000000,
        ST_CLAB  = 14'b00000100000000,
        ST_NB    = 14'b00001000000000,
        ST_NCHK  = 14'b00010000000000,
        ST_TNB   = 14'b00100000000000,
        ST_TCHK  = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_BOOT:
            begin
                ctl.clr_en = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_MARK:
            begin
                ctl.obst   = 1'b1;
                state_next = ST_DONE;
            end
            ST_STEP:
            begin
                ctl.step_read = 1'b1;
                state_next    = ST_DONE;
            end
            ST_CLR:
            begin
                ctl.clr_en = 1'b1;
                if (st.clr_last)
                begin
                    state_next = (st.cmd == CMD_CLEAR) ? ST_DONE : ST_SINIT;
                end
            end
            ST_SINIT:
            begin
                priority if (st.ep_bad)
                begin
                    state_next = ST_DONE;
                end
                else if (st.ep_same)
                begin
                    ctl.trivial = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ctl.seed   = 1'b1;
                    state_next = ST_QRD;
                end
            end
            ST_QRD:
            begin
                if (st.q_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.q_read = 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_CRD:
            begin
                ctl.cell_load = 1'b1;
                state_next    = ST_CLAB;
            end
            ST_CLAB:
            begin
                ctl.lab_load  = 1'b1;
                ctl.dir_reset = 1'b1;
                state_next    = ST_NB;
            end
            ST_NB:
            begin
                priority if (!st.nb_valid)
                begin
                    if (st.dir_last)
                    begin
                        state_next = ST_QRD;
                    end
                    else
                    begin
                        ctl.dir_next = 1'b1;
                    end
                end
                else if (st.nb_is_goal)
                begin
                    ctl.goal_hit  = 1'b1;
                    ctl.dir_reset = 1'b1;
                    state_next    = ST_TNB;
                end
                else
                begin
                    state_next = ST_NCHK;
                end
            end
            ST_NCHK:
            begin
                ctl.nb_commit = st.nb_free;
                if (st.dir_last)
                begin
                    state_next = ST_QRD;
                end
                else
                begin
                    ctl.dir_next = 1'b1;
                    state_next   = ST_NB;
                end
            end
            ST_TNB:
            begin
                priority if (st.pos_zero)
                begin
                    ctl.tr_found = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (!st.nb_valid)
                begin
                    if (st.dir_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ctl.dir_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_TCHK;
                end
            end
            ST_TCHK:
            begin
                priority if (st.tr_hit)
                begin
                    ctl.tr_move   = 1'b1;
                    ctl.dir_reset = 1'b1;
                    state_next    = ST_TNB;
                end
                else if (st.dir_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.dir_next = 1'b1;
                    state_next   = ST_TNB;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // dispatch on the freshly accepted word
        if (ctl.load_item)
        begin
            unique case (st.new_cmd)
                CMD_MARK:   state_next = ST_MARK;
                CMD_SEARCH: state_next = ST_CLR;
                CMD_STEP:   state_next = ST_STEP;
                CMD_CLEAR:  state_next = ST_CLR;
                default:    state_next = ST_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/gmr_dpath.sv
// ---------------------------------------------------------------------------
// gmr_dpath
// Maps, wave queue, path store, neighbor logic and result register.
// ---------------------------------------------------------------------------
`include "grid_maze_router_defines.svh"

module gmr_dpath #(
    parameter int GRID_COLS = 32,
    parameter int GRID_ROWS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gmr_pkg::ctrl_t               ctl,
    output gmr_pkg::stat_t               st,
    input  gmr_pkg::cmd_t                command,
    input  logic [gmr_pkg::COORD_W-1:0]  cell_col,
    input  logic [gmr_pkg::COORD_W-1:0]  cell_row,
    input  logic [gmr_pkg::STEP_W-1:0]   step_index,
    input  logic                         cfg_wr_en,
    input  gmr_pkg::cfg_reg_t            cfg_index,
    input  logic [gmr_pkg::COORD_W-1:0]  cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         rejected,
    output logic                         found,
    output logic [gmr_pkg::LEN_W-1:0]    path_length,
    output logic [gmr_pkg::COORD_W-1:0]  step_col,
    output logic [gmr_pkg::COORD_W-1:0]  step_row
);
    import gmr_pkg::*;

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int QW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 2);

    // configuration
    logic [COORD_W-1:0] start_col_reg, start_row_reg, goal_col_reg, goal_row_reg;

    // accepted word
    cmd_t               cmd_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [STEP_W-1:0]  idx_reg;

    // search state
    logic [AW-1:0]  clr_addr_reg;
    logic [QW:0]    head_reg, tail_reg;
    logic [AW-1:0]  cell_reg;
    logic [LW-1:0]  lab_reg, glab_reg, pos_reg;
    dir_t           dir_reg;
    logic [LW-1:0]  path_count_reg;
    logic           found_reg;

    // memories
    logic [LW-1:0]  dist_mem [0:DEPTH-1];
    logic           blk_mem  [0:DEPTH-1];
    logic [AW-1:0]  queue_mem[0:CELLS-1];
    logic [AW-1:0]  path_mem [0:CELLS-1];
    logic [LW-1:0]  dist_rd;
    logic           blk_rd;
    logic [AW-1:0]  q_rd, path_rd;

    // result register
    logic               out_valid_reg;
    logic               out_rej_reg, out_found_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [COORD_W-1:0] out_col_reg, out_row_reg;

    logic [AW-1:0]  s_addr, g_addr, nb_addr;
    logic [CW-1:0]  cur_col, nb_col;
    logic [RW-1:0]  cur_row, nb_row;
    logic           nb_valid, rej, step_ok;
    logic [LW-1:0]  lab_inc, pos_dec;

    logic           dist_we;
    logic [AW-1:0]  dist_waddr, dist_raddr;
    logic [LW-1:0]  dist_wdata;
    logic           blk_we, blk_wdata;
    logic           q_we;
    logic [QW-1:0]  q_waddr;
    logic [AW-1:0]  q_wdata;
    logic           p_we;
    logic [QW-1:0]  p_waddr;
    logic [AW-1:0]  p_wdata;

    assign s_addr  = {RW'(start_row_reg), CW'(start_col_reg)};
    assign g_addr  = {RW'(goal_row_reg), CW'(goal_col_reg)};
    assign cur_col = cell_reg[CW-1:0];
    assign cur_row = cell_reg[AW-1:CW];
    assign lab_inc = lab_reg + 1'b1;
    assign pos_dec = pos_reg - 1'b1;

    always_comb
    begin
        nb_col   = cur_col;
        nb_row   = cur_row;
        nb_valid = 1'b0;
        unique case (dir_reg)
            DIR_RIGHT:
            begin
                nb_valid = (32'(cur_col) + 32'd1) < GRID_COLS;
                nb_col   = cur_col + 1'b1;
            end
            DIR_UP:
            begin
                nb_valid = (cur_row != '0);
                nb_row   = cur_row - 1'b1;
            end
            DIR_LEFT:
            begin
                nb_valid = (cur_col != '0);
                nb_col   = cur_col - 1'b1;
            end
            DIR_DOWN:
            begin
                nb_valid = (32'(cur_row) + 32'd1) < GRID_ROWS;
                nb_row   = cur_row + 1'b1;
            end
            default:
            begin
                nb_valid = 1'b0;
            end
        endcase
    end

    assign nb_addr = {nb_row, nb_col};

    assign rej = (32'(col_reg) >= GRID_COLS) || (32'(row_reg) >= GRID_ROWS) ||
                 (col_reg == start_col_reg && row_reg == start_row_reg) ||
                 (col_reg == goal_col_reg && row_reg == goal_row_reg);
    assign step_ok = (32'(idx_reg) < 32'(path_count_reg)) && (32'(idx_reg) < CELLS);

    always_comb
    begin
        st            = '0;
        st.cmd        = cmd_reg;
        st.new_cmd    = command;
        st.clr_last   = &clr_addr_reg;
        st.ep_bad     = (32'(start_col_reg) >= GRID_COLS) || (32'(start_row_reg) >= GRID_ROWS) ||
                        (32'(goal_col_reg) >= GRID_COLS) || (32'(goal_row_reg) >= GRID_ROWS);
        st.ep_same    = (start_col_reg == goal_col_reg) && (start_row_reg == goal_row_reg);
        st.q_empty    = (head_reg == tail_reg);
        st.nb_valid   = nb_valid;
        st.nb_is_goal = (nb_addr == g_addr);
        st.nb_free    = !blk_rd && (dist_rd == '0);
        st.dir_last   = (dir_reg == DIR_DOWN);
        st.pos_zero   = (pos_reg == '0);
        st.tr_hit     = (dist_rd != '0) && (dist_rd < lab_reg);
        st.out_free   = !out_valid_reg || out_ready;
    end

    // ---- memory write and read selection ----
    always_comb
    begin
        dist_we    = 1'b1;
        dist_waddr = nb_addr;
        dist_wdata = lab_inc;
        priority if (ctl.clr_en)
        begin
            dist_waddr = clr_addr_reg;
            dist_wdata = '0;
        end
        else if (ctl.seed)
        begin
            dist_waddr = s_addr;
            dist_wdata = LW'(1);
        end
        else if (ctl.goal_hit || ctl.nb_commit)
        begin
            dist_waddr = nb_addr;
        end
        else
        begin
            dist_we = 1'b0;
        end
        dist_raddr = ctl.cell_load ? q_rd : nb_addr;

        blk_we    = (ctl.clr_en && cmd_reg == CMD_CLEAR) || (ctl.obst && !rej);
        blk_wdata = ctl.obst;

        q_we    = ctl.seed || (ctl.nb_commit && (tail_reg < (QW+1)'(CELLS)));
        q_waddr = ctl.seed ? '0 : tail_reg[QW-1:0];
        q_wdata = ctl.seed ? s_addr : nb_addr;

        p_we    = ctl.trivial || ctl.goal_hit || ctl.tr_move;
        p_waddr = QW'(pos_dec);
        p_wdata = nb_addr;
        priority if (ctl.trivial)
        begin
            p_waddr = '0;
            p_wdata = s_addr;
        end
        else if (ctl.goal_hit)
        begin
            p_waddr = QW'(lab_reg);
        end
        else
        begin
            p_waddr = QW'(pos_dec);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd <= dist_mem[dist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[ctl.obst ? {RW'(row_reg), CW'(col_reg)} : clr_addr_reg] <= blk_wdata;
        end
        blk_rd <= blk_mem[nb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (ctl.q_read)
        begin
            q_rd <= queue_mem[head_reg[QW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            path_mem[p_waddr] <= p_wdata;
        end
        if (ctl.step_read && step_ok)
        begin
            path_rd <= path_mem[QW'(idx_reg)];
        end
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_col_reg  <= START_COL_RST;
            start_row_reg  <= START_ROW_RST;
            goal_col_reg   <= GOAL_COL_RST;
            goal_row_reg   <= GOAL_ROW_RST;
            cmd_reg        <= CMD_CLEAR;
            clr_addr_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            dir_reg        <= DIR_RIGHT;
            path_count_reg <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_START_COL: start_col_reg <= cfg_data;
                    REG_START_ROW: start_row_reg <= cfg_data;
                    REG_GOAL_COL:  goal_col_reg  <= cfg_data;
                    REG_GOAL_ROW:  goal_row_reg  <= cfg_data;
                    default:       start_col_reg <= start_col_reg;
                endcase
            end
            if (ctl.load_item)
            begin
                cmd_reg <= command;
                if (command == CMD_SEARCH)
                begin
                    path_count_reg <= '0;
                    found_reg      <= 1'b0;
                end
            end
            if (ctl.clr_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (ctl.seed)
            begin
                head_reg <= '0;
                tail_reg <= (QW+1)'(1);
            end
            else
            begin
                if (ctl.q_read)
                begin
                    head_reg <= head_reg + 1'b1;
                end
                if (ctl.nb_commit && (tail_reg < (QW+1)'(CELLS)))
                begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            if (ctl.dir_reset)
            begin
                dir_reg <= DIR_RIGHT;
            end
            else if (ctl.dir_next)
            begin
                dir_reg <= dir_t'(dir_reg + 2'd1);
            end
            if (ctl.trivial)
            begin
                path_count_reg <= LW'(1);
                found_reg      <= 1'b1;
            end
            if (ctl.tr_found)
            begin
                path_count_reg <= glab_reg;
                found_reg      <= 1'b1;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            col_reg <= cell_col;
            row_reg <= cell_row;
            idx_reg <= step_index;
        end
        if (ctl.cell_load)
        begin
            cell_reg <= q_rd;
        end
        else if (ctl.goal_hit || ctl.tr_move)
        begin
            cell_reg <= nb_addr;
        end
        if (ctl.lab_load)
        begin
            lab_reg <= dist_rd;
        end
        else if (ctl.goal_hit)
        begin
            lab_reg <= lab_inc;
        end
        else if (ctl.tr_move)
        begin
            lab_reg <= dist_rd;
        end
        if (ctl.goal_hit)
        begin
            glab_reg <= lab_inc;
            pos_reg  <= lab_reg;
        end
        else if (ctl.tr_move)
        begin
            pos_reg <= pos_dec;
        end
        if (ctl.out_load)
        begin
            out_rej_reg   <= (cmd_reg == CMD_MARK) && rej;
            out_found_reg <= found_reg;
            out_len_reg   <= LEN_W'(path_count_reg);
            out_col_reg   <= ((cmd_reg == CMD_STEP) && step_ok) ?
                             COORD_W'(path_rd[CW-1:0]) : '0;
            out_row_reg   <= ((cmd_reg == CMD_STEP) && step_ok) ?
                             COORD_W'(path_rd[AW-1:CW]) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rejected    = out_rej_reg;
    assign found       = out_found_reg;
    assign path_length = out_len_reg;
    assign step_col    = out_col_reg;
    assign step_row    = out_row_reg;

    `GMR_ASSERT_NOW(a_tail_bound, clk, rst_n, 1'b1, tail_reg <= (QW+1)'(CELLS),
        "wave queue tail ran past the cell count")
    `GMR_ASSERT_NOW(a_head_le_tail, clk, rst_n, 1'b1, head_reg <= tail_reg,
        "wave queue head passed the tail")
    `GMR_ASSERT_NOW(a_found_len, clk, rst_n, found_reg, path_count_reg != '0,
        "found set with an empty path")
    `GMR_ASSERT_NEXT(a_out_load, clk, rst_n, ctl.out_load, out_valid_reg,
        "result word loaded but not presented")

endmodule

>>> hdl/grid_maze_router.sv
// ---------------------------------------------------------------------------
// grid_maze_router
// Lee maze router: obstacle marking, grid clear, wave search, path read.
// ---------------------------------------------------------------------------
// One word is worked at a time. Mark obstacle and read path step go from
// accept through their own work state to the result register. Clear grid
// sweeps both maps over every address. A search first sweeps the label map
// the same way, then expands the wave: for each dequeued cell it reads the
// queue, then the cell's label, then probes its neighbors in turn; it then
// traces back from the goal, probing neighbors for a lower label at each
// path step. After reset the block sweeps both maps before it takes its
// first word; configuration writes are taken throughout.
module grid_maze_router #(
    parameter int GRID_COLS = 32,
    parameter int GRID_ROWS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    gmr_in_if.sink                       request,
    gmr_out_if.source                    response,
    input  logic                         cfg_wr_en,
    input  gmr_pkg::cfg_reg_t            cfg_index,
    input  logic [gmr_pkg::COORD_W-1:0]  cfg_data
);
    import gmr_pkg::*;

    ctrl_t ctl;
    stat_t st;

    gmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .st       (st),
        .ctl      (ctl)
    );

    gmr_dpath #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .st          (st),
        .command     (request.command),
        .cell_col    (request.cell_col),
        .cell_row    (request.cell_row),
        .step_index  (request.step_index),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (response.ready),
        .out_valid   (response.valid),
        .rejected    (response.rejected),
        .found       (response.found),
        .path_length (response.path_length),
        .step_col    (response.step_col),
        .step_row    (response.step_row)
    );

endmodule

>>> sim/tb_grid_maze_router.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_maze_router
// Self-checking bench for the maze router: a behavioral model of the grid
// predicts every response word; the sender idles in bursts and the receiver
// stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_grid_maze_router;
    import gmr_pkg::*;

    localparam int NCOLS = 32;
    localparam int NROWS = 32;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        logic             rejected;
        logic             found;
        logic [LEN_W-1:0] path_length;
        logic [COORD_W-1:0] step_col;
        logic [COORD_W-1:0] step_row;
    } rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cfg_reg_t cfg_index;
    logic [COORD_W-1:0] cfg_data;

    gmr_in_if  req_if ();
    gmr_out_if rsp_if ();

    grid_maze_router u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if.sink),
        .response (rsp_if.source),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // model state
    int unsigned label_map [NCELLS];
    bit          wall_map [NCELLS];
    int unsigned bfs_queue [NCELLS];
    int unsigned route [NCELLS];
    int unsigned route_len;
    bit          route_ok;
    int unsigned s_col, s_row, g_col, g_row;

    rsp_t expected_q[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   timed_out = 1'b0;
    int   burst_left;
    int   stall_phase = 0;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit neighbor(int unsigned node, int d, output int unsigned nxt);
        int unsigned c;
        int unsigned r;
        c = node % NCOLS;
        r = node / NCOLS;
        case (d)
            DIR_RIGHT: begin if (c + 1 >= NCOLS) return 0; c++; end
            DIR_UP:    begin if (r == 0) return 0; r--; end
            DIR_LEFT:  begin if (c == 0) return 0; c--; end
            default:   begin if (r + 1 >= NROWS) return 0; r++; end
        endcase
        nxt = r * NCOLS + c;
        return 1;
    endfunction

    task automatic route_search();
        int unsigned src;
        int unsigned dst;
        int unsigned head;
        int unsigned tail;
        int unsigned node;
        int unsigned nb;
        int unsigned pos;
        bit reached;
        bit moved;
        foreach (label_map[i]) label_map[i] = 0;
        route_len = 0;
        route_ok = 0;
        head = 0;
        tail = 0;
        reached = 0;
        if (s_col >= NCOLS || s_row >= NROWS || g_col >= NCOLS || g_row >= NROWS) return;
        src = s_row * NCOLS + s_col;
        dst = g_row * NCOLS + g_col;
        if (src == dst)
        begin
            route[0] = src;
            route_len = 1;
            route_ok = 1;
            return;
        end
        label_map[src] = 1;
        bfs_queue[tail++] = src;
        while (head < tail && !reached)
        begin
            node = bfs_queue[head++];
            for (int d = 0; d < 4; d++)
            begin
                if (!neighbor(node, d, nb)) continue;
                if (nb == dst)
                begin
                    label_map[dst] = label_map[node] + 1;
                    reached = 1;
                    break;
                end
                if (wall_map[nb] || label_map[nb] != 0) continue;
                label_map[nb] = label_map[node] + 1;
                if (tail < NCELLS) bfs_queue[tail++] = nb;
            end
        end
        if (!reached) return;
        pos = label_map[dst] - 1;
        if (pos >= NCELLS) return;
        node = dst;
        route[pos] = dst;
        while (pos > 0)
        begin
            moved = 0;
            for (int d = 0; d < 4; d++)
            begin
                if (!neighbor(node, d, nb)) continue;
                if (label_map[nb] != 0 && label_map[nb] < label_map[node])
                begin
                    moved = 1;
                    break;
                end
            end
            if (!moved) return;
            pos--;
            route[pos] = nb;
            node = nb;
        end
        route_len = label_map[dst];
        route_ok = 1;
    endtask

    task automatic predict_word(cmd_t cmd, int unsigned col, int unsigned row,
                                int unsigned idx);
        rsp_t r;
        r = '0;
        case (cmd)
            CMD_MARK:
                if (col >= NCOLS || row >= NROWS || (col == s_col && row == s_row) ||
                    (col == g_col && row == g_row))
                    r.rejected = 1'b1;
                else
                    wall_map[row * NCOLS + col] = 1'b1;
            CMD_SEARCH: route_search();
            CMD_STEP:
                if (idx < route_len)
                begin
                    r.step_col = COORD_W'(route[idx] % NCOLS);
                    r.step_row = COORD_W'(route[idx] / NCOLS);
                end
            default:
            begin
                foreach (label_map[i]) label_map[i] = 0;
                foreach (wall_map[i]) wall_map[i] = 0;
            end
        endcase
        r.found = route_ok;
        r.path_length = LEN_W'(route_len);
        expected_q.push_back(r);
    endtask

    // one request word; bursts with random gaps in between
    task automatic send_word(cmd_t cmd, int unsigned col, int unsigned row, int unsigned idx);
        if (burst_left == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.command <= cmd;
        req_if.cell_col <= COORD_W'(col);
        req_if.cell_row <= COORD_W'(row);
        req_if.step_index <= STEP_W'(idx);
        predict_word(cmd, col & 32'd31, row & 32'd31, idx & 32'd1023);
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0 && !timed_out) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= COORD_W'(val);
        case (idx)
            REG_START_COL: s_col = val & 32'd31;
            REG_START_ROW: s_row = val & 32'd31;
            REG_GOAL_COL:  g_col = val & 32'd31;
            default:       g_row = val & 32'd31;
        endcase
        @(negedge clk);
    endtask

    task automatic set_endpoints(int unsigned sc, int unsigned sr, int unsigned gc,
                                 int unsigned gr);
        wait_drained();
        write_reg(REG_START_COL, sc);
        write_reg(REG_START_ROW, sr);
        write_reg(REG_GOAL_COL, gc);
        write_reg(REG_GOAL_ROW, gr);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic read_route(int unsigned n);
        for (int i = 0; i < n; i++) send_word(CMD_STEP, 0, 0, i);
    endtask

    task automatic test_directed();
        send_word(CMD_STEP, 31, 31, 0);
        send_word(CMD_MARK, 0, 0, 1023);     // on start
        send_word(CMD_MARK, 31, 31, 0);      // on goal
        send_word(CMD_MARK, 31, 0, 0);
        send_word(CMD_MARK, 0, 31, 0);
        send_word(CMD_SEARCH, 0, 0, 0);
        send_word(CMD_STEP, 0, 0, 0);
        send_word(CMD_STEP, 0, 0, 62);
        send_word(CMD_STEP, 0, 0, 63);       // past end
        send_word(CMD_STEP, 0, 0, 1023);
        send_word(CMD_CLEAR, 0, 0, 0);       // keeps last route
        send_word(CMD_STEP, 0, 0, 5);
        set_endpoints(5, 5, 5, 5);           // start equals goal
        send_word(CMD_SEARCH, 0, 0, 0);
        send_word(CMD_STEP, 0, 0, 0);
        set_endpoints(3, 3, 3, 5);
        // boxed-in start: search fails
        send_word(CMD_MARK, 4, 3, 0);
        send_word(CMD_MARK, 2, 3, 0);
        send_word(CMD_MARK, 3, 2, 0);
        send_word(CMD_MARK, 3, 4, 0);
        send_word(CMD_SEARCH, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        // moved endpoint onto an old wall
        send_word(CMD_MARK, 6, 6, 0);
        set_endpoints(6, 6, 9, 6);
        send_word(CMD_SEARCH, 0, 0, 0);
        read_route(4);
    endtask

    task automatic test_random();
        int n;
        int unsigned pick;
        n = 0;
        while (n < 110)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                set_endpoints($urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom_range(0, 7));
                send_word(CMD_CLEAR, $urandom, $urandom, $urandom);
                n++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_word(CMD_MARK, $urandom_range(0, 9), $urandom_range(0, 9),
                          $urandom_range(0, 1023));
            else if (pick < 6)
                send_word(CMD_MARK, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 1023));
            else if (pick < 8)
            begin
                send_word(CMD_SEARCH, $urandom, $urandom, $urandom);
                read_route($urandom_range(1, 3));
                n += 2;
            end
            else
                send_word(CMD_STEP, $urandom, $urandom, $urandom_range(0, 20));
            n++;
        end
        set_endpoints(31, 31, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        send_word(CMD_SEARCH, 0, 0, 0);
        send_word(CMD_STEP, 0, 0, 62);
    endtask

    // receiver stall pattern and response check
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        rsp_if.ready <= (stall_phase[6:5] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) timed_out <= 1'b1;
        end
        if (rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.rejected, rsp_if.found, rsp_if.path_length,
                    rsp_if.step_col, rsp_if.step_row};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rej=%0d fnd=%0d len=%0d col=%0d row=%0d,",
                                 want.rejected, want.found, want.path_length,
                                 want.step_col, want.step_row,
                                 " got rej=%0d fnd=%0d len=%0d col=%0d row=%0d",
                                 got.rejected, got.found,
                                 got.path_length, got.step_col, got.step_row);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_START_COL;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_MARK;
        req_if.cell_col = '0;
        req_if.cell_row = '0;
        req_if.step_index = '0;
        burst_left = 0;
        route_len = 0;
        route_ok = 0;
        s_col = START_COL_RST;
        s_row = START_ROW_RST;
        g_col = GOAL_COL_RST;
        g_row = GOAL_ROW_RST;
        foreach (label_map[i]) label_map[i] = 0;
        foreach (wall_map[i]) wall_map[i] = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        fork
            begin
                test_directed();
                test_random();
                wait_drained();
            end
            wait (timed_out);
        join_any
        if (!timed_out && mismatches == 0 && expected_q.size() == 0)
            $display("tb_grid_maze_router OK");
        else
            $display("tb_grid_maze_router NOT OK");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hdl
hdl/gmr_pkg.sv
hdl/gmr_in_if.sv
hdl/gmr_out_if.sv
hdl/gmr_ctrl.sv
hdl/gmr_dpath.sv
hdl/grid_maze_router.sv
sim/tb_grid_maze_router.sv
